/* rtl/periodic_pair_repeat_counter_macros.svh */
// Assertion macros shared by the periodic pair repeat counter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PERIODIC_PAIR_REPEAT_COUNTER_MACROS_SVH
`define PERIODIC_PAIR_REPEAT_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define PPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/ppr_pkg.sv */
`timescale 1ns / 1ps
// Package for the periodic pair repeat counter: widths, defaults, queue entry
// type and table state type. No dependencies.
package ppr_pkg;

   localparam int MAX_PERIOD_DEFAULT = 64;
   localparam int ALPHABET_DEFAULT   = 26;
   localparam int LETTER_W           = 5;
   localparam int PERIOD_W           = 7;
   localparam int TOTAL_W            = 10;
   localparam int COUNT_W            = 2;
   localparam int EPOCH_W            = 8;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd21;
   localparam logic [COUNT_W-1:0]  COUNT_SAT    = 2'd2;
   localparam logic [COUNT_W-1:0]  COUNT_ONCE   = 2'd1;

   // One classified letter on its way from the front to the table.
   typedef struct packed {
      logic                pair;
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                last;
   } pair_entry_type;

   typedef enum logic {
      ST_SWEEP,
      ST_RUN
   } table_state_type;

endpackage

/* rtl/periodic_pair_repeat_counter.sv */
`timescale 1ns / 1ps
// Top level of the periodic pair repeat counter: period register, front,
// queue and back. Depends on ppr_pkg, ppr_front, ppr_queue and ppr_back.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_letter[4:0], req_last
//   rsp      out        rsp_valid / rsp_ready  rsp_repeated_pairs[9:0]
//   csr      in         csr_valid / csr_ready  csr_period[6:0]
//
// Throughput is one letter per cycle when nothing stalls: the front does one
// history ring read and write per letter, the back one count table
// read-modify-write per letter, with the last write forwarded to the next
// read of the same pair. When nothing stalls, a last letter is loaded into
// the front stage on the edge that accepts it, then passes the queue, the
// table read and the result register, which drives rsp_valid.
// After reset the table is swept, all ALPHABET*ALPHABET entries (676 by
// default); the same sweep runs after every 2**8 messages when the epoch
// mark wraps. req_ready stays low while a full queue holds the front stage,
// as a sweep or a stalled rsp can cause; csr writes are taken every cycle.
// A stalled rsp holds only a last letter in the back; the queue absorbs
// the front meanwhile.
module periodic_pair_repeat_counter #(
   parameter int MAX_PERIOD = ppr_pkg::MAX_PERIOD_DEFAULT,
   parameter int ALPHABET   = ppr_pkg::ALPHABET_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ppr_pkg::LETTER_W-1:0] req_letter,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ppr_pkg::TOTAL_W-1:0]  rsp_repeated_pairs,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ppr_pkg::PERIOD_W-1:0] csr_period
);

   logic [ppr_pkg::PERIOD_W-1:0] period_ff, period_in;

   logic                    fq_valid;
   logic                    fq_ready;
   ppr_pkg::pair_entry_type fq_entry;
   logic                    qb_valid;
   logic                    qb_ready;
   ppr_pkg::pair_entry_type qb_entry;

   // Period register: always ready, new value applies from the next letter.
   assign csr_ready = 1'b1;
   assign period_in = (csr_valid && csr_ready) ? csr_period : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ppr_pkg::PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // Front: ring history, pairs each letter with the one a period back.
   ppr_front #(
      .MAX_PERIOD (MAX_PERIOD),
      .ALPHABET   (ALPHABET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_period (period_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_letter (req_letter),
      .req_last   (req_last),
      .out_valid  (fq_valid),
      .out_ready  (fq_ready),
      .out_entry  (fq_entry)
   );

   // Queue: decouple front from table stalls and sweeps.
   ppr_queue #(
      .DEPTH (ppr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_entry (fq_entry),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_entry  (qb_entry)
   );

   // Back: count pairs, accumulate repeats, emit on the last letter.
   ppr_back #(
      .ALPHABET (ALPHABET)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (qb_valid),
      .in_ready           (qb_ready),
      .in_entry           (qb_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_repeated_pairs (rsp_repeated_pairs)
   );

endmodule

/* rtl/ppr_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered, enabled read.
// Read returns the old contents on a same-address write. No dependencies.
module ppr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/ppr_front.sv */
`timescale 1ns / 1ps
// Front of the periodic pair repeat counter: letter history ring and pair
// classification. Depends on ppr_pkg, ppr_ram and the macros header.
`include "periodic_pair_repeat_counter_macros.svh"
module ppr_front #(
   parameter int MAX_PERIOD = ppr_pkg::MAX_PERIOD_DEFAULT,
   parameter int ALPHABET   = ppr_pkg::ALPHABET_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ppr_pkg::PERIOD_W-1:0]  cfg_period,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ppr_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ppr_pkg::pair_entry_type       out_entry
);

   localparam int AW = $clog2(MAX_PERIOD);
   localparam int SW = $clog2(MAX_PERIOD + 1);
   localparam int CW = (SW > ppr_pkg::PERIOD_W) ? SW : ppr_pkg::PERIOD_W;
   localparam int EW = SW + 1;

   logic [AW-1:0] wp_ff, wp_in;
   logic [SW-1:0] seen_ff, seen_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_pair_ff, s1_pair_in;
   logic          s1_last_ff, s1_last_in;
   logic [ppr_pkg::LETTER_W-1:0] s1_letter_ff, s1_letter_in;

   logic [CW-1:0] period_wide;
   logic [SW-1:0] eff_period;
   logic [EW-1:0] wp_ext;
   logic [EW-1:0] rd_sum;
   logic [AW-1:0] rd_addr;
   logic          accept;
   logic          push;
   logic [ppr_pkg::LETTER_W-1:0] hist_rdata;

   // Clamp the period into 1 .. MAX_PERIOD.
   always_comb begin
      period_wide = CW'(cfg_period);
      if (cfg_period == '0) begin
         eff_period = SW'(1);
      end else if (period_wide > CW'(MAX_PERIOD)) begin
         eff_period = SW'(MAX_PERIOD);
      end else begin
         eff_period = SW'(period_wide);
      end
   end

   // Ring position of the letter one period back.
   always_comb begin
      wp_ext  = EW'(wp_ff);
      rd_sum  = wp_ext + ((wp_ext >= EW'(eff_period)) ? EW'(0) : EW'(MAX_PERIOD))
                - EW'(eff_period);
      rd_addr = rd_sum[AW-1:0];
   end

   assign push      = s1_valid_ff && out_ready;
   assign req_ready = !s1_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      s1_valid_in  = push ? 1'b0 : s1_valid_ff;
      s1_pair_in   = s1_pair_ff;
      s1_last_in   = s1_last_ff;
      s1_letter_in = s1_letter_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_pair_in   = (seen_ff >= eff_period) && (int'(req_letter) < ALPHABET);
         s1_last_in   = req_last;
         s1_letter_in = req_letter;
         if (req_last) begin
            wp_in   = '0;
            seen_in = '0;
         end else begin
            wp_in   = (wp_ff == AW'(MAX_PERIOD - 1)) ? '0 : wp_ff + AW'(1);
            seen_in = (seen_ff < SW'(MAX_PERIOD)) ? seen_ff + SW'(1) : seen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         seen_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         seen_ff     <= seen_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_pair_ff   <= s1_pair_in;
      s1_last_ff   <= s1_last_in;
      s1_letter_ff <= s1_letter_in;
   end

   ppr_ram #(
      .WIDTH (ppr_pkg::LETTER_W),
      .DEPTH (MAX_PERIOD)
   ) u_history (
      .clock (clock),
      .we    (accept),
      .waddr (wp_ff),
      .wdata (req_letter),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (hist_rdata)
   );

   assign out_valid        = s1_valid_ff;
   assign out_entry.pair   = s1_pair_ff && (int'(hist_rdata) < ALPHABET);
   assign out_entry.first  = hist_rdata;
   assign out_entry.second = s1_letter_ff;
   assign out_entry.last   = s1_last_ff;

   `PPR_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !out_ready,
      s1_valid_ff && $stable(s1_letter_ff) && $stable(s1_last_ff))
   `PPR_ASSERT_NOW(a_seen_range, clock, reset, 1'b1, seen_ff <= SW'(MAX_PERIOD))
   `PPR_ASSERT_NEXT(a_last_clears, clock, reset, accept && req_last,
      seen_ff == '0 && wp_ff == '0)

endmodule

/* rtl/ppr_queue.sv */
`timescale 1ns / 1ps
// Small register FIFO of classified letters between front and back.
// Depends on ppr_pkg.
module ppr_queue #(
   parameter int DEPTH = ppr_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  ppr_pkg::pair_entry_type push_entry,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output ppr_pkg::pair_entry_type pop_entry
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   ppr_pkg::pair_entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != NW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/ppr_back.sv */
`timescale 1ns / 1ps
// Back of the periodic pair repeat counter: pair count table with epoch
// marks, read-modify-write with forwarding, repeat total and result register.
// Depends on ppr_pkg, ppr_ram and the macros header.
`include "periodic_pair_repeat_counter_macros.svh"
module ppr_back #(
   parameter int ALPHABET = ppr_pkg::ALPHABET_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ppr_pkg::pair_entry_type      in_entry,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ppr_pkg::TOTAL_W-1:0]  rsp_repeated_pairs
);

   localparam int TD = ALPHABET * ALPHABET;
   localparam int IW = $clog2(TD);
   localparam int CW = ppr_pkg::COUNT_W;
   localparam int MW = ppr_pkg::EPOCH_W + CW;

   ppr_pkg::table_state_type state_ff, state_in;
   logic [IW-1:0]  sweep_idx_ff, sweep_idx_in;

   logic                    b1_valid_ff, b1_valid_in;
   ppr_pkg::pair_entry_type b1_entry_ff, b1_entry_in;
   logic [IW-1:0]           b1_idx_ff, b1_idx_in;

   logic          wr_valid_ff, wr_valid_in;
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [MW-1:0] wr_data_ff, wr_data_in;

   logic [ppr_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ppr_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ppr_pkg::TOTAL_W-1:0] rsp_value_ff, rsp_value_in;

   logic          sweeping;
   logic [IW-1:0] in_idx;
   logic [MW-1:0] tbl_rdata;
   logic [MW-1:0] word;
   logic [CW-1:0] cur_count;
   logic [CW-1:0] new_count;
   logic          bump;
   logic          advance;
   logic          tbl_we_pair;
   logic          sweep_start;
   logic          pop;
   logic [ppr_pkg::TOTAL_W-1:0] total_sum;
   logic          tbl_we;
   logic [IW-1:0] tbl_waddr;
   logic [MW-1:0] tbl_wdata;

   // Table state: sweep the whole table after reset and on epoch wrap.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppr_pkg::ST_SWEEP: begin
            if (sweep_idx_ff == IW'(TD - 1)) begin
               state_in = ppr_pkg::ST_RUN;
            end
         end
         ppr_pkg::ST_RUN: begin
            if (sweep_start) begin
               state_in = ppr_pkg::ST_SWEEP;
            end
         end
         default: state_in = ppr_pkg::ST_SWEEP;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ppr_pkg::ST_SWEEP: sweeping = 1'b1;
         ppr_pkg::ST_RUN:   sweeping = 1'b0;
         default:           sweeping = 1'b1;
      endcase
   end

   assign in_idx = in_entry.pair ?
                   IW'(int'(in_entry.first) * ALPHABET + int'(in_entry.second)) : '0;

   // Forward the previous write; stale epochs read as zero.
   always_comb begin
      word      = (wr_valid_ff && (wr_idx_ff == b1_idx_ff)) ? wr_data_ff : tbl_rdata;
      cur_count = (word[MW-1:CW] == epoch_ff) ? word[CW-1:0] : '0;
      new_count = (cur_count == ppr_pkg::COUNT_SAT) ? cur_count : cur_count + CW'(1);
      bump      = b1_entry_ff.pair && (cur_count == ppr_pkg::COUNT_ONCE) && (total_ff != '1);
      total_sum = total_ff + ppr_pkg::TOTAL_W'(bump);
   end

   assign advance     = b1_valid_ff && (!b1_entry_ff.last || !rsp_valid_ff || rsp_ready);
   assign tbl_we_pair = advance && b1_entry_ff.pair;
   assign sweep_start = advance && b1_entry_ff.last && (epoch_ff == '1);
   assign in_ready    = !sweeping && !sweep_start && (!b1_valid_ff || advance);
   assign pop         = in_valid && in_ready;

   always_comb begin
      sweep_idx_in = sweeping ? sweep_idx_ff + IW'(1) : '0;
      b1_valid_in  = pop ? 1'b1 : (advance ? 1'b0 : b1_valid_ff);
      b1_entry_in  = pop ? in_entry : b1_entry_ff;
      b1_idx_in    = pop ? in_idx : b1_idx_ff;
      wr_valid_in  = wr_valid_ff;
      wr_idx_in    = wr_idx_ff;
      wr_data_in   = wr_data_ff;
      if (sweeping) begin
         wr_valid_in = 1'b0;
      end else if (tbl_we_pair) begin
         wr_valid_in = 1'b1;
         wr_idx_in   = b1_idx_ff;
         wr_data_in  = {epoch_ff, new_count};
      end
      epoch_in     = epoch_ff;
      total_in     = total_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready);
      rsp_value_in = rsp_value_ff;
      if (advance) begin
         if (b1_entry_ff.last) begin
            epoch_in     = epoch_ff + ppr_pkg::EPOCH_W'(1);
            total_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_value_in = total_sum;
         end else begin
            total_in = total_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppr_pkg::ST_SWEEP;
         sweep_idx_ff <= '0;
         b1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         epoch_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
         b1_valid_ff  <= b1_valid_in;
         wr_valid_ff  <= wr_valid_in;
         epoch_ff     <= epoch_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b1_entry_ff  <= b1_entry_in;
      b1_idx_ff    <= b1_idx_in;
      wr_idx_ff    <= wr_idx_in;
      wr_data_ff   <= wr_data_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign tbl_we    = sweeping || tbl_we_pair;
   assign tbl_waddr = sweeping ? sweep_idx_ff : b1_idx_ff;
   assign tbl_wdata = sweeping ? '0 : {epoch_ff, new_count};

   ppr_ram #(
      .WIDTH (MW),
      .DEPTH (TD)
   ) u_counts (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (pop),
      .raddr (in_idx),
      .rdata (tbl_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_repeated_pairs = rsp_value_ff;

   `PPR_ASSERT_NOW(a_no_pop_in_sweep, clock, reset, sweeping, !pop && !tbl_we_pair)
   `PPR_ASSERT_NEXT(a_total_clear, clock, reset, advance && b1_entry_ff.last,
      total_ff == '0)
   `PPR_ASSERT_NEXT(a_fwd_dropped, clock, reset, sweeping, !wr_valid_ff)

endmodule

/* sim/periodic_pair_repeat_counter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for periodic_pair_repeat_counter: a directed table,
// then randomized letter streams under varied pacing, each checked against an
// in-bench pair-count predictor. Depends on ppr_pkg and the RTL top level.
module periodic_pair_repeat_counter_tb;

   localparam int RING_DEPTH   = ppr_pkg::MAX_PERIOD_DEFAULT;
   localparam int LETTERS      = ppr_pkg::ALPHABET_DEFAULT;
   localparam int PAIRS        = LETTERS * LETTERS;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 77;
   localparam int PHASES       = 12;
   localparam logic [ppr_pkg::TOTAL_W-1:0] TOTAL_CEIL = '1;

   typedef enum logic {ROW_LETTER, ROW_PERIOD} row_kind_type;
   typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   typedef struct {
      row_kind_type                  kind;
      logic [ppr_pkg::PERIOD_W-1:0]  value;   // letter code or period
      logic                          last;
      logic                          typed;   // want holds a hand-written total
      logic [ppr_pkg::TOTAL_W-1:0]   want;
   } plan_row_type;

   localparam logic [ppr_pkg::PERIOD_W-1:0] PHASE_PERIODS [PHASES] = '{
      7'd1, 7'd64, 7'd2, 7'd3, 7'd127, 7'd21, 7'd0, 7'd65, 7'd5, 7'd42, 7'd8, 7'd96
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [ppr_pkg::LETTER_W-1:0] req_letter = '0;
   logic                         req_last = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [ppr_pkg::TOTAL_W-1:0]  rsp_repeated_pairs;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [ppr_pkg::PERIOD_W-1:0] csr_period = '0;

   periodic_pair_repeat_counter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_letter         (req_letter),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_repeated_pairs (rsp_repeated_pairs),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_period         (csr_period)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: period register, letter ring, pair counters, totals.
   logic [ppr_pkg::PERIOD_W-1:0] period_reg = ppr_pkg::PERIOD_RESET;
   logic [ppr_pkg::LETTER_W-1:0] letter_ring [RING_DEPTH];
   logic [ppr_pkg::COUNT_W-1:0]  pair_tally [PAIRS];
   int unsigned                  seen_count = 0;
   int unsigned                  ring_pos = 0;
   logic [ppr_pkg::TOTAL_W-1:0]  repeat_sum = '0;

   logic [ppr_pkg::TOTAL_W-1:0]  pending_totals [$];
   plan_row_type                 plan [$];
   int                           errors = 0;
   int                           send_idle_pct = 0;
   int                           stall_pct = 0;
   int                           hold_ticket = 0;
   int                           hold_served = 0;
   int                           hold_left = 0;

   initial begin
      foreach (letter_ring[i]) letter_ring[i] = '0;
      foreach (pair_tally[i]) pair_tally[i] = '0;
   end

   function automatic int unsigned effective_period(
         input logic [ppr_pkg::PERIOD_W-1:0] p);
      if (p == 0) return 1;
      if (p > RING_DEPTH) return RING_DEPTH;
      return p;
   endfunction

   // Advance the predictor by one letter; return 1 with the total on a last letter.
   function automatic logic count_letter(input logic [ppr_pkg::LETTER_W-1:0] ltr,
                                         input logic lst,
                                         output logic [ppr_pkg::TOTAL_W-1:0] total);
      int unsigned p;
      int unsigned idx;
      logic [ppr_pkg::LETTER_W-1:0] first;
      p = effective_period(period_reg);
      total = '0;
      if (seen_count >= p) begin
         first = letter_ring[(ring_pos + RING_DEPTH - p) % RING_DEPTH];
         // pairs touching a code outside the alphabet are not counted
         if (first < LETTERS && ltr < LETTERS) begin
            idx = first * LETTERS + ltr;
            if (pair_tally[idx] == ppr_pkg::COUNT_ONCE && repeat_sum < TOTAL_CEIL)
               repeat_sum = repeat_sum + 1'b1;
            if (pair_tally[idx] < ppr_pkg::COUNT_SAT)
               pair_tally[idx] = pair_tally[idx] + 1'b1;
         end
      end
      letter_ring[ring_pos] = ltr;
      ring_pos = (ring_pos + 1) % RING_DEPTH;
      if (seen_count < RING_DEPTH) seen_count++;
      if (!lst) return 1'b0;
      total = repeat_sum;
      foreach (pair_tally[i]) pair_tally[i] = '0;
      seen_count = 0;
      ring_pos = 0;
      repeat_sum = '0;
      return 1'b1;
   endfunction

   task automatic add_row(input row_kind_type kind, input int value, input logic lst,
                          input logic typed, input int want);
      plan_row_type row;
      row.kind  = kind;
      row.value = value[ppr_pkg::PERIOD_W-1:0];
      row.last  = lst;
      row.typed = typed;
      row.want  = want[ppr_pkg::TOTAL_W-1:0];
      plan.push_back(row);
   endtask

   task automatic wait_drained();
      while (pending_totals.size() != 0) @(posedge clock);
   endtask

   task automatic send_letter(input logic [ppr_pkg::LETTER_W-1:0] ltr, input logic lst,
                              input logic typed, input logic [ppr_pkg::TOTAL_W-1:0] want);
      logic [ppr_pkg::TOTAL_W-1:0] total;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_letter <= ltr;
      req_last   <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (count_letter(ltr, lst, total))
         pending_totals.push_back(typed ? want : total);
   endtask

   // Write the period only once the block has gone quiet.
   task automatic write_period(input logic [ppr_pkg::PERIOD_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid  <= 1'b1;
      csr_period <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      period_reg = value;
   endtask

   // Receiver pacing; a new hold ticket forces a long stall.
   always @(posedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_totals.size() == 0) begin
            if (errors < 10)
               $display("unexpected result: repeated_pairs %0d", rsp_repeated_pairs);
            errors++;
         end else begin
            if (rsp_repeated_pairs !== pending_totals[0]) begin
               if (errors < 10)
                  $display("mismatch: repeated_pairs expected %0d got %0d",
                           pending_totals[0], rsp_repeated_pairs);
               errors++;
            end
            void'(pending_totals.pop_front());
         end
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      pace_type                     pace;
      int                           sent;
      int                           msgs;
      int                           len;
      int                           span;
      int                           base;
      int unsigned                  eff;
      logic [ppr_pkg::LETTER_W-1:0] ltr;

      // message at the reset period, too short to pair
      add_row(ROW_LETTER, 10, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 10, 1'b1, 1'b1, 0);
      // period zero acts as one: AAA repeats the pair AA
      add_row(ROW_PERIOD, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b1, 1'b1, 1);
      add_row(ROW_LETTER, 31, 1'b1, 1'b1, 0);
      // codes past Z never count
      add_row(ROW_LETTER, 26, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 26, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 26, 1'b1, 1'b1, 0);
      add_row(ROW_LETTER, 25, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 25, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 25, 1'b1, 1'b1, 1);
      // period above the ring depth clamps; short message gives zero
      add_row(ROW_PERIOD, 127, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 2, 1'b1, 1'b1, 0);
      add_row(ROW_PERIOD, 2, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b1, 1'b0, 0);
      // period changed in the middle of a message
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_PERIOD, 1, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LETTER, 1, 1'b1, 1'b0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_PERIOD)
            write_period(plan[i].value);
         else
            send_letter(plan[i].value[ppr_pkg::LETTER_W-1:0], plan[i].last, plan[i].typed,
                        plan[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         pace = pace_type'(ph % 4);
         case (pace)
            PACE_FULL:       begin send_idle_pct = 0;  stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 65; stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 65; end
            default:         begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         write_period(PHASE_PERIODS[ph]);
         eff = effective_period(PHASE_PERIODS[ph]);
         // hold off the receiver while short messages back up the block
         if (ph == 4) hold_ticket++;
         sent = 0;
         msgs = 0;
         while (sent < PHASE_ITEMS) begin
            if (ph == 4 && sent < 40)
               len = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 50)
               len = $urandom_range(1, 4);
            else
               len = $urandom_range(1, 2 * eff + 8);
            // keep each phase at its letter budget
            if (len > PHASE_ITEMS - sent)
               len = PHASE_ITEMS - sent;
            case ($urandom_range(0, 2))
               0:       span = 3;
               1:       span = 6;
               default: span = LETTERS;
            endcase
            base = $urandom_range(0, LETTERS - span);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 19) == 0)
                  ltr = ppr_pkg::LETTER_W'($urandom_range(LETTERS, 31));
               else
                  ltr = ppr_pkg::LETTER_W'(base + int'($urandom_range(0, span - 1)));
               send_letter(ltr, k == len - 1, 1'b0, '0);
            end
            sent += len;
            msgs++;
            // pause the sender until every result is back
            if (pace == PACE_BOTH && msgs % 4 == 0) begin
               req_valid <= 1'b0;
               wait_drained();
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      errors += pending_totals.size();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
